FILE: hdl/uer_pkg.sv
// Package for the ultrasonic echo ranging block: widths, constants,
// status codes and configuration register indexes.
// No dependencies.
package uer_pkg;

    localparam int TEMP_W   = 15;
    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = 17;
    localparam int DIST_W   = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // arithmetic unit: one 25x26 multiplier; constant divides multiply by a
    // rounded-up reciprocal and keep the high bits
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 26;
    localparam int ACC_W    = MUL_A_W + MUL_B_W;
    localparam int SPEED_W  = 16;

    // |T|*606/1000 = |T|*303/500, exact for |T| up to 2^14
    localparam int TEMP_SHIFT = 23;
    localparam int TEMP_Q_W   = 14;
    localparam logic [MUL_B_W-1:0] TEMP_RECIP = MUL_B_W'(5083497);

    // x/2000000 = (x >> 7)/15625, exact for (x >> 7) below 2^25
    localparam int DIST_PRE_SHIFT = 7;
    localparam int DIST_SHIFT     = 39;
    localparam logic [MUL_B_W-1:0] DIST_RECIP = MUL_B_W'(35184373);

    localparam logic [SPEED_W-1:0] SPEED_BASE = SPEED_W'(33130);
    localparam logic [SPEED_W-1:0] SPEED_MIN  = SPEED_W'(30000);

    localparam logic [LIMIT_W-1:0] START_LIMIT_RST  = LIMIT_W'(5000);
    localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = LIMIT_W'(20000);
    localparam logic [COUNT_W-1:0] LOW_TICKS  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] HIGH_TICKS = COUNT_W'(10);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_EN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd2;

endpackage

FILE: hdl/ultrasonic_echo_ranging_top.sv
// Ultrasonic echo ranging sequencer: trigger/echo phase tracking per tick,
// distance computed by one shared multiplier with reciprocal constants.
// Depends on uer_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  req      | req_valid / req_stall | command, echo_level, temperature_cdeg
//  rsp      | rsp_valid / rsp_stall | trigger_level, busy_res, done_res,
//           |                       | status, distance_cm
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A tick or start beat loads its result straight into the output register.
// A beat that ends an echo pulse runs through the accept, a first pass of the
// shared multiplier (|T| by the 0.606 reciprocal), the speed clamp, two more
// passes (pulse by speed, the /2000000 reciprocal) and the result load.
// req_stall is high while that computation runs or while a result is stalled.
// Reset is asynchronous; limits return to 5000 / 20000 us, enabled to 0.
module ultrasonic_echo_ranging_top
    import uer_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      command,
    input  logic                      echo_level,
    input  logic signed [TEMP_W-1:0]  temperature_cdeg,

    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      trigger_level,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [STATUS_W-1:0]       status,
    output logic [DIST_W-1:0]         distance_cm,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [LIMIT_W-1:0]        cfg_data
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT      = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_MUL_T = 3'd1;
    localparam logic [2:0] C_SPEED = 3'd2;
    localparam logic [2:0] C_MUL_D = 3'd3;
    localparam logic [2:0] C_DIV_D = 3'd4;
    localparam logic [2:0] C_DONE  = 3'd5;

    logic                     enabled_reg;
    logic [LIMIT_W-1:0]       start_limit_reg;
    logic [LIMIT_W-1:0]       length_limit_reg;

    logic [2:0]               phase_reg, phase_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [TEMP_W-1:0]        temp_reg, temp_next;
    logic [COUNT_W-1:0]       pulse_reg, pulse_next;

    logic [2:0]               calc_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     neg_reg;
    logic [SPEED_W-1:0]       speed_reg;

    logic                     rsp_valid_reg;
    logic                     trig_reg, busy_reg, done_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [DIST_W-1:0]        dist_reg;

    logic                     req_fire;
    logic                     out_free;
    logic [COUNT_W-1:0]       count_inc;
    logic                     o_trig, o_busy, o_done, start_calc;
    logic [STATUS_W-1:0]      o_status;

    // shared arithmetic
    logic [TEMP_W:0]          temp_ext;
    logic [TEMP_W:0]          temp_abs;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [ACC_W-1:0]         mul_prod;
    logic [TEMP_Q_W-1:0]      temp_quot;
    logic [SPEED_W:0]         speed_raw;

    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (calc_reg != C_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_fire  = req_valid && !req_stall;
    assign count_inc = count_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            start_limit_reg  <= START_LIMIT_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLED:      enabled_reg      <= cfg_data[0];
                CFG_START_LIMIT:  start_limit_reg  <= cfg_data;
                CFG_LENGTH_LIMIT: length_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // phase tracking for one accepted beat
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        temp_next  = temp_reg;
        pulse_next = pulse_reg;
        o_trig     = 1'b0;
        o_busy     = 1'b0;
        o_done     = 1'b0;
        o_status   = ST_OK;
        start_calc = 1'b0;
        if (command)
        begin
            if (phase_reg != PH_IDLE)
            begin
                o_trig = (phase_reg == PH_TRIG_HIGH);
                o_busy = 1'b1;
            end
            else if (!enabled_reg)
            begin
                o_done   = 1'b1;
                o_status = ST_NOT_EN;
            end
            else
            begin
                temp_next  = temperature_cdeg;
                phase_next = PH_TRIG_LOW;
                count_next = '0;
                o_busy     = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_TRIG_LOW:
                begin
                    o_busy = 1'b1;
                    if (count_inc >= LOW_TICKS)
                    begin
                        phase_next = PH_TRIG_HIGH;
                        count_next = '0;
                        o_trig     = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    o_busy = 1'b1;
                    if (count_inc >= HIGH_TICKS)
                    begin
                        phase_next = PH_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                        o_trig     = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    if (echo_level)
                    begin
                        phase_next = PH_MEASURE;
                        count_next = '0;
                        o_busy     = 1'b1;
                    end
                    else if (count_inc > {1'b0, start_limit_reg})
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        o_done     = 1'b1;
                        o_status   = ST_TIMEOUT;
                    end
                    else
                    begin
                        count_next = count_inc;
                        o_busy     = 1'b1;
                    end
                end
                PH_MEASURE:
                begin
                    if (!echo_level)
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        pulse_next = count_inc;
                        start_calc = 1'b1;
                    end
                    else if (count_inc > {1'b0, length_limit_reg})
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        o_done     = 1'b1;
                        o_status   = ST_TIMEOUT;
                    end
                    else
                    begin
                        count_next = count_inc;
                        o_busy     = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        temp_ext = {temp_reg[TEMP_W-1], temp_reg};
        temp_abs = temp_reg[TEMP_W-1] ? (~temp_ext + (TEMP_W+1)'(1)) : temp_ext;
        if (calc_reg == C_MUL_T)
        begin
            mul_a = MUL_A_W'(temp_abs);
            mul_b = TEMP_RECIP;
        end
        else if (calc_reg == C_MUL_D)
        begin
            mul_a = MUL_A_W'(pulse_reg);
            mul_b = MUL_B_W'(speed_reg);
        end
        else
        begin
            // pulse*speed fits 32 bits; drop the 2^7 factor of 2000000 first
            mul_a = acc_reg[DIST_PRE_SHIFT +: MUL_A_W];
            mul_b = DIST_RECIP;
        end
        mul_prod  = mul_a * mul_b;
        // truncated |T|*606/1000, below 2^14
        temp_quot = acc_reg[TEMP_SHIFT +: TEMP_Q_W];
        if (neg_reg)
            speed_raw = {1'b0, SPEED_BASE} - (SPEED_W+1)'(temp_quot);
        else
            speed_raw = {1'b0, SPEED_BASE} + (SPEED_W+1)'(temp_quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            temp_reg      <= '0;
            calc_reg      <= C_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                temp_reg  <= temp_next;
                if (start_calc)
                    calc_reg <= C_MUL_T;
            end
            unique case (calc_reg)
                C_IDLE:  ;
                C_MUL_T: calc_reg <= C_SPEED;
                C_SPEED: calc_reg <= C_MUL_D;
                C_MUL_D: calc_reg <= C_DIV_D;
                C_DIV_D: calc_reg <= C_DONE;
                C_DONE:
                begin
                    if (out_free)
                        calc_reg <= C_IDLE;
                end
                default: calc_reg <= C_IDLE;
            endcase
            if ((req_fire && !start_calc) || (calc_reg == C_DONE && out_free))
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        if (req_fire && start_calc)
            pulse_reg <= pulse_next;
        if (req_fire && !start_calc)
        begin
            trig_reg   <= o_trig;
            busy_reg   <= o_busy;
            done_reg   <= o_done;
            status_reg <= o_status;
            dist_reg   <= '0;
        end
        unique case (calc_reg)
            C_MUL_T:
            begin
                acc_reg <= mul_prod;
                neg_reg <= temp_reg[TEMP_W-1];
            end
            C_SPEED:
            begin
                if (speed_raw < {1'b0, SPEED_MIN})
                    speed_reg <= SPEED_MIN;
                else
                    speed_reg <= speed_raw[SPEED_W-1:0];
            end
            C_MUL_D, C_DIV_D:
            begin
                acc_reg <= mul_prod;
            end
            C_DONE:
            begin
                if (out_free)
                begin
                    trig_reg   <= 1'b0;
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    status_reg <= ST_OK;
                    dist_reg   <= acc_reg[DIST_SHIFT +: DIST_W];
                end
            end
            default: ;
        endcase
    end

    assign rsp_valid     = rsp_valid_reg;
    assign trigger_level = trig_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign status        = status_reg;
    assign distance_cm   = dist_reg;

    // no result is pending while the distance is being computed
    a_calc_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_reg != C_IDLE && calc_reg != C_DONE) |-> !rsp_valid_reg)
        else $error("result pending during distance computation");

    // a finished computation always leaves a result behind
    a_calc_result: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_reg == C_DONE && out_free) |=> (rsp_valid_reg && done_reg))
        else $error("distance result lost");

    // a non-final result carries neither status nor distance
    a_open_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !done_reg) |-> (status_reg == ST_OK && dist_reg == '0))
        else $error("status or distance on a non-final result");

    // a final result is never busy and a distance comes only with ok
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && done_reg) |->
            (!busy_reg && !trig_reg && (dist_reg == '0 || status_reg == ST_OK)))
        else $error("inconsistent final result");

    // no measurement is in flight while the distance is computed
    a_calc_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_reg != C_IDLE) |-> (phase_reg == PH_IDLE))
        else $error("phase advanced during distance computation");

endmodule
